[rtl/hrhp_pkg.sv]
`default_nettype none

package hrhp_pkg;

  localparam int unsigned OffsetBitsDefault   = 32;
  localparam int unsigned LengthBitsDefault   = 32;

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSp    = 8'h20;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic [3:0] NameLen   = 4'd14;
  localparam logic [2:0] PrefixLen = 3'd5;

  // classified byte handed from the front to the back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       take;
    logic       last;
    logic       found;
  } item_t;

  typedef struct packed {
    logic        header_found;
    logic [31:0] header_length;
    logic [15:0] status_code;
    logic        length_found;
    logic [31:0] content_length;
    logic        looks_like_response;
  } res_t;

  function automatic logic [7:0] name_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = "c";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = "l";
      4'd9:    c = "e";
      4'd10:   c = "n";
      4'd11:   c = "g";
      4'd12:   c = "t";
      4'd13:   c = "h";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = "H";
      3'd1:    c = "T";
      3'd2:    c = "T";
      3'd3:    c = "P";
      3'd4:    c = "/";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= ChZero) && (b <= ChNine);
  endfunction

  function automatic logic is_break(input logic [7:0] b);
    return (b == ChCr) || (b == ChLf);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return ((b >= "A") && (b <= "Z")) ? b + 8'd32 : b;
  endfunction

endpackage

`default_nettype wire

[rtl/hrhp_if.sv]
`default_nettype none

interface hrhp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hrhp_res_if;
  logic        valid;
  logic        ready;
  logic        header_found;
  logic [31:0] header_length;
  logic [15:0] status_code;
  logic        length_found;
  logic [31:0] content_length;
  logic        looks_like_response;

  modport source (output valid, output header_found, output header_length,
                  output status_code, output length_found, output content_length,
                  output looks_like_response, input ready);
  modport sink   (input valid, input header_found, input header_length,
                  input status_code, input length_found, input content_length,
                  input looks_like_response, output ready);
endinterface

`default_nettype wire

[rtl/http_response_header_parser.sv]
// A result transaction is registered: the last byte passes through the queue and then sets the result register.
// Throughput: one byte per cycle; the front detects the header end, a two-entry
// queue decouples it from the field parsers, and a result register holds the output.
// The input stalls only when the queue is full, i.e. a result waits on the sink.
// Reset: asynchronous, active low; all parser state and the queue are cleared.
`default_nettype none

module http_response_header_parser #(
  parameter int unsigned OFFSET_BITS       = hrhp_pkg::OffsetBitsDefault,
  parameter int unsigned LENGTH_VALUE_BITS = hrhp_pkg::LengthBitsDefault
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  hrhp_byte_if.sink    rx_i,
  hrhp_res_if.source   res_o
);

  hrhp_pkg::item_t front_item;
  hrhp_pkg::item_t back_item;
  hrhp_pkg::res_t  res;
  logic            full, push, pop, q_valid;

  assign rx_i.ready = ~full;
  assign push       = rx_i.valid & ~full;

  hrhp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_byte_i (rx_i.data_byte),
    .last_byte_i (rx_i.last_byte),
    .item_o      (front_item)
  );

  hrhp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (back_item)
  );

  hrhp_back #(
    .OFFSET_BITS       (OFFSET_BITS),
    .LENGTH_VALUE_BITS (LENGTH_VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .item_i      (back_item),
    .pop_o       (pop),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .res_o       (res)
  );

  assign res_o.header_found        = res.header_found;
  assign res_o.header_length       = res.header_length;
  assign res_o.status_code         = res.status_code;
  assign res_o.length_found        = res.length_found;
  assign res_o.content_length      = res.content_length;
  assign res_o.looks_like_response = res.looks_like_response;

endmodule

`default_nettype wire

[rtl/hrhp_front.sv]
`default_nettype none

// Header end detection; tags each byte as header or not.
module hrhp_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire logic [7:0]     data_byte_i,
  input  wire logic           last_byte_i,
  output hrhp_pkg::item_t     item_o
);

  logic [1:0] brk_q, brk_d;
  logic       crp_q, crp_d;
  logic       endp_q, endp_d;
  logic       hdone_q, hdone_d;

  always_comb begin
    logic       mode_lf;
    logic       skip;
    logic       finish;
    logic [1:0] nb;
    brk_d   = brk_q;
    crp_d   = crp_q;
    endp_d  = endp_q;
    hdone_d = hdone_q;
    mode_lf = 1'b0;
    skip    = 1'b0;
    finish  = 1'b0;
    nb      = (brk_q < 2'd2) ? brk_q + 2'd1 : brk_q;
    item_o.take = 1'b0;
    if (!hdone_q) begin
      if (crp_q) begin
        crp_d = 1'b0;
        if (data_byte_i == hrhp_pkg::ChLf) begin
          mode_lf = 1'b1;
          if (endp_q) begin
            endp_d = 1'b0;
            finish = 1'b1;
          end
        end else if (endp_q) begin
          endp_d  = 1'b0;
          hdone_d = 1'b1;
          skip    = 1'b1;
        end
      end
      if (!skip) begin
        item_o.take = 1'b1;
        if (!mode_lf) begin
          if (hrhp_pkg::is_break(data_byte_i)) begin
            brk_d = nb;
            if (data_byte_i == hrhp_pkg::ChCr) crp_d = 1'b1;
            if (nb >= 2'd2) begin
              if (data_byte_i == hrhp_pkg::ChCr) endp_d = 1'b1;
              else hdone_d = 1'b1;
            end
          end else begin
            brk_d = 2'd0;
          end
        end
        if (finish) hdone_d = 1'b1;
      end
    end
    item_o.data_byte = data_byte_i;
    item_o.last      = last_byte_i;
    item_o.found     = hdone_d | endp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brk_q   <= 2'd0;
      crp_q   <= 1'b0;
      endp_q  <= 1'b0;
      hdone_q <= 1'b0;
    end else if (push_i) begin
      if (last_byte_i) begin
        brk_q   <= 2'd0;
        crp_q   <= 1'b0;
        endp_q  <= 1'b0;
        hdone_q <= 1'b0;
      end else begin
        brk_q   <= brk_d;
        crp_q   <= crp_d;
        endp_q  <= endp_d;
        hdone_q <= hdone_d;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/hrhp_fifo.sv]
`default_nettype none

module hrhp_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire hrhp_pkg::item_t item_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output hrhp_pkg::item_t      item_o
);

  hrhp_pkg::item_t mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

`default_nettype wire

[rtl/hrhp_back.sv]
`default_nettype none

// Field parsers over header bytes; builds one result per buffer.
module hrhp_back #(
  parameter int unsigned OFFSET_BITS       = hrhp_pkg::OffsetBitsDefault,
  parameter int unsigned LENGTH_VALUE_BITS = hrhp_pkg::LengthBitsDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire hrhp_pkg::item_t item_i,
  output logic                 pop_o,
  output logic                 res_valid_o,
  input  wire logic            res_ready_i,
  output hrhp_pkg::res_t       res_o
);

  localparam logic [1:0] StFirst  = 2'd0;
  localparam logic [1:0] StSpaces = 2'd1;
  localparam logic [1:0] StDigits = 2'd2;
  localparam logic [1:0] StDone   = 2'd3;

  localparam logic [2:0] LnName   = 3'd0;
  localparam logic [2:0] LnBlank  = 3'd1;
  localparam logic [2:0] LnValue  = 3'd2;
  localparam logic [2:0] LnSkip   = 3'd3;
  localparam logic [2:0] LnTaken  = 3'd4;

  localparam int unsigned LB = LENGTH_VALUE_BITS;

  logic [OFFSET_BITS-1:0] off_q, off_d;
  logic [1:0]             sph_q, sph_d;
  logic [15:0]            sval_q, sval_d;
  logic [2:0]             lph_q, lph_d;
  logic [3:0]             npos_q, npos_d;
  logic                   nmat_q, nmat_d;
  logic                   lseen_q, lseen_d;
  logic [LB-1:0]          lval_q, lval_d;
  logic                   pmat_q, pmat_d;
  logic                   res_valid_q;
  hrhp_pkg::res_t         res_q, res_d;

  logic [7:0] b;
  assign b = item_i.data_byte;

  assign pop_o       = valid_i & (~item_i.last | ~res_valid_q | res_ready_i);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    logic [LB+3:0] lwide;
    logic [15:0]   swide;
    logic [7:0]    d8;
    logic [63:0]   off_ext;
    logic [63:0]   len_ext;
    off_d   = off_q;
    sph_d   = sph_q;
    sval_d  = sval_q;
    lph_d   = lph_q;
    npos_d  = npos_q;
    nmat_d  = nmat_q;
    lseen_d = lseen_q;
    lval_d  = lval_q;
    pmat_d  = pmat_q;
    d8      = b - hrhp_pkg::ChZero;
    lwide   = ({4'd0, lval_q} << 3) + ({4'd0, lval_q} << 1) + (LB+4)'(d8[3:0]);
    swide   = (sval_q << 3) + (sval_q << 1) + {12'd0, d8[3:0]};

    if (item_i.take) begin
      if ((off_q < OFFSET_BITS'(hrhp_pkg::PrefixLen)) &&
          (b != hrhp_pkg::prefix_char(off_q[2:0]))) pmat_d = 1'b0;
      if (off_q != '1) off_d = off_q + 1'b1;

      case (sph_q)
        StFirst: begin
          if (b == hrhp_pkg::ChSp) sph_d = StSpaces;
        end
        StSpaces: begin
          if (hrhp_pkg::is_digit(b)) begin
            sph_d  = StDigits;
            sval_d = {12'd0, d8[3:0]};
          end else if (b != hrhp_pkg::ChSp) begin
            sph_d = StDone;
          end
        end
        StDigits: begin
          if (hrhp_pkg::is_digit(b)) sval_d = swide;
          else sph_d = StDone;
        end
        default: ;
      endcase

      case (lph_q)
        LnName: begin
          if (hrhp_pkg::is_break(b)) begin
            npos_d = 4'd0;
            nmat_d = 1'b1;
          end else if (b == hrhp_pkg::ChColon) begin
            if (nmat_q && (npos_q == hrhp_pkg::NameLen)) begin
              lseen_d = 1'b1;
              lval_d  = '0;
              lph_d   = LnBlank;
            end else begin
              lph_d = LnSkip;
            end
          end else if (nmat_q && (npos_q < hrhp_pkg::NameLen) &&
                       (hrhp_pkg::to_lower(b) == hrhp_pkg::name_char(npos_q))) begin
            npos_d = npos_q + 4'd1;
          end else begin
            nmat_d = 1'b0;
          end
        end
        LnBlank: begin
          if (hrhp_pkg::is_digit(b)) begin
            lval_d = LB'(d8[3:0]);
            lph_d  = LnValue;
          end else if ((b != hrhp_pkg::ChSp) && (b != hrhp_pkg::ChTab)) begin
            lph_d = LnTaken;
          end
        end
        LnValue: begin
          if (hrhp_pkg::is_digit(b)) begin
            if (lwide[LB+3:LB] != 4'd0) lval_d = '1;
            else lval_d = lwide[LB-1:0];
          end else begin
            lph_d = LnTaken;
          end
        end
        LnSkip: begin
          if (hrhp_pkg::is_break(b)) begin
            lph_d  = LnName;
            npos_d = 4'd0;
            nmat_d = 1'b1;
          end
        end
        default: ;
      endcase
    end

    off_ext = 64'(off_d);
    len_ext = 64'(lval_d);
    res_d.header_found   = item_i.found;
    res_d.header_length  = !item_i.found ? 32'd0 :
                           (off_ext > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : off_ext[31:0];
    res_d.status_code    = item_i.found ? sval_d : 16'd0;
    res_d.length_found   = item_i.found & lseen_d;
    res_d.content_length = !(item_i.found && lseen_d) ? 32'd0 :
                           (len_ext > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : len_ext[31:0];
    res_d.looks_like_response = pmat_d &&
                                (off_d >= OFFSET_BITS'(hrhp_pkg::PrefixLen));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q   <= '0;
      sph_q   <= StFirst;
      sval_q  <= 16'd0;
      lph_q   <= LnName;
      npos_q  <= 4'd0;
      nmat_q  <= 1'b1;
      lseen_q <= 1'b0;
      lval_q  <= '0;
      pmat_q  <= 1'b1;
    end else if (pop_o) begin
      if (item_i.last) begin
        off_q   <= '0;
        sph_q   <= StFirst;
        sval_q  <= 16'd0;
        lph_q   <= LnName;
        npos_q  <= 4'd0;
        nmat_q  <= 1'b1;
        lseen_q <= 1'b0;
        lval_q  <= '0;
        pmat_q  <= 1'b1;
      end else begin
        off_q   <= off_d;
        sph_q   <= sph_d;
        sval_q  <= sval_d;
        lph_q   <= lph_d;
        npos_q  <= npos_d;
        nmat_q  <= nmat_d;
        lseen_q <= lseen_d;
        lval_q  <= lval_d;
        pmat_q  <= pmat_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (pop_o && item_i.last) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && item_i.last) res_q <= res_d;
  end

endmodule

`default_nettype wire

[rtl/hrhp_checker.sv]
`default_nettype none

module hrhp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        res_valid_i,
  input wire logic        res_ready_i,
  input wire logic        header_found_i,
  input wire logic [31:0] header_length_i,
  input wire logic [15:0] status_code_i,
  input wire logic        length_found_i,
  input wire logic [31:0] content_length_i,
  input wire logic        looks_like_response_i
);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result valid dropped while stalled");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(header_length_i) && $stable(content_length_i))
    else $error("result payload changed while stalled");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !header_found_i |-> header_length_i == 32'd0 &&
      status_code_i == 16'd0 && !length_found_i)
    else $error("fields set without a header end");

  a_no_length_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !length_found_i |-> content_length_i == 32'd0)
    else $error("content length without a Content-Length line");

  a_prefix_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && header_found_i && looks_like_response_i |-> header_length_i >= 32'd5)
    else $error("response prefix flagged on a short header");

endmodule

bind http_response_header_parser hrhp_checker u_hrhp_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .res_valid_i           (res_o.valid),
  .res_ready_i           (res_o.ready),
  .header_found_i        (res_o.header_found),
  .header_length_i       (res_o.header_length),
  .status_code_i         (res_o.status_code),
  .length_found_i        (res_o.length_found),
  .content_length_i      (res_o.content_length),
  .looks_like_response_i (res_o.looks_like_response)
);

`default_nettype wire

[verif/tb_top.sv]
`default_nettype none

module tb_top;

  localparam int CycleLimit = 200000;
  localparam int HoldOffCycles = 400;

  // Predicts one summary per buffer and keeps the summaries still owed by the block.
  class resp_header_scoreboard;
    typedef enum logic [1:0] {StToken, StBlank, StDigits, StOver} status_phase_e;
    typedef enum logic [2:0] {LnName, LnBlank, LnDigits, LnSkip, LnTaken} line_phase_e;

    string cl_name = "content-length";
    string resp_prefix = "HTTP/";

    logic [31:0]   offset;
    logic [1:0]    breaks;
    bit            cr_wait;
    bit            end_wait;
    bit            hdr_done;
    status_phase_e st_phase;
    logic [15:0]   st_value;
    line_phase_e   ln_phase;
    logic [3:0]    name_pos;
    bit            name_ok;
    bit            cl_seen;
    logic [31:0]   cl_value;
    bit            prefix_ok;

    hrhp_pkg::res_t pending_summaries[$];
    int   failures;

    function new();
      failures = 0;
      clear();
    endfunction

    function void clear();
      offset    = '0;
      breaks    = '0;
      cr_wait   = 1'b0;
      end_wait  = 1'b0;
      hdr_done  = 1'b0;
      st_phase  = StToken;
      st_value  = '0;
      ln_phase  = LnName;
      name_pos  = '0;
      name_ok   = 1'b1;
      cl_seen   = 1'b0;
      cl_value  = '0;
      prefix_ok = 1'b1;
    endfunction

    function void scan_status(logic [7:0] b);
      bit dig;
      dig = (b >= hrhp_pkg::ChZero) && (b <= hrhp_pkg::ChNine);
      case (st_phase)
        StToken: begin
          if (b == hrhp_pkg::ChSp) st_phase = StBlank;
        end
        StBlank: begin
          if (dig) begin
            st_phase = StDigits;
            st_value = 16'(b - hrhp_pkg::ChZero);
          end else if (b != hrhp_pkg::ChSp) begin
            st_phase = StOver;
          end
        end
        StDigits: begin
          if (dig) st_value = st_value * 16'd10 + 16'(b - hrhp_pkg::ChZero);
          else st_phase = StOver;
        end
        default: ;
      endcase
    endfunction

    function void scan_length(logic [7:0] b);
      bit              dig;
      bit              brk;
      logic [7:0]      low;
      longint unsigned acc;
      dig = (b >= hrhp_pkg::ChZero) && (b <= hrhp_pkg::ChNine);
      brk = (b == hrhp_pkg::ChCr) || (b == hrhp_pkg::ChLf);
      low = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
      case (ln_phase)
        LnName: begin
          if (brk) begin
            name_pos = '0;
            name_ok  = 1'b1;
          end else if (b == hrhp_pkg::ChColon) begin
            if (name_ok && name_pos == hrhp_pkg::NameLen) begin
              cl_seen  = 1'b1;
              cl_value = '0;
              ln_phase = LnBlank;
            end else begin
              ln_phase = LnSkip;
            end
          end else if (name_ok && name_pos < hrhp_pkg::NameLen &&
                       low == cl_name[name_pos]) begin
            name_pos++;
          end else begin
            name_ok = 1'b0;
          end
        end
        LnBlank: begin
          if (dig) begin
            cl_value = 32'(b - hrhp_pkg::ChZero);
            ln_phase = LnDigits;
          end else if (b != hrhp_pkg::ChSp && b != hrhp_pkg::ChTab) begin
            ln_phase = LnTaken;
          end
        end
        LnDigits: begin
          if (dig) begin
            acc = longint'(cl_value) * 10 + longint'(b - hrhp_pkg::ChZero);
            cl_value = (acc > 64'hFFFF_FFFF) ? '1 : acc[31:0];
          end else begin
            ln_phase = LnTaken;
          end
        end
        LnSkip: begin
          if (brk) begin
            ln_phase = LnName;
            name_pos = '0;
            name_ok  = 1'b1;
          end
        end
        default: ;
      endcase
    endfunction

    function void take_header_byte(logic [7:0] b);
      if (offset < hrhp_pkg::PrefixLen && b != resp_prefix[offset[2:0]]) prefix_ok = 1'b0;
      if (offset != '1) offset++;
      scan_status(b);
      scan_length(b);
    endfunction

    function void note_byte(logic [7:0] b, bit is_last);
      bit   finish;
      bit   skip;
      bit   after_crlf;
      hrhp_pkg::res_t r;
      if (!hdr_done) begin
        finish     = 1'b0;
        skip       = 1'b0;
        after_crlf = 1'b0;
        if (cr_wait) begin
          cr_wait = 1'b0;
          if (b == hrhp_pkg::ChLf) begin
            after_crlf = 1'b1;
            if (end_wait) begin
              end_wait = 1'b0;
              finish   = 1'b1;
            end
          end else if (end_wait) begin
            // CR closed the header, this byte is body
            end_wait = 1'b0;
            hdr_done = 1'b1;
            skip     = 1'b1;
          end
        end
        if (!skip) begin
          take_header_byte(b);
          if (!after_crlf) begin
            if (b == hrhp_pkg::ChCr || b == hrhp_pkg::ChLf) begin
              if (breaks < 2) breaks++;
              if (b == hrhp_pkg::ChCr) cr_wait = 1'b1;
              if (breaks >= 2) begin
                if (b == hrhp_pkg::ChCr) end_wait = 1'b1;
                else hdr_done = 1'b1;
              end
            end else begin
              breaks = '0;
            end
          end
          if (finish) hdr_done = 1'b1;
        end
      end
      if (is_last) begin
        if (end_wait) hdr_done = 1'b1;
        r.header_found        = hdr_done;
        r.header_length       = hdr_done ? offset : '0;
        r.status_code         = hdr_done ? st_value : '0;
        r.length_found        = hdr_done && cl_seen;
        r.content_length      = (hdr_done && cl_seen) ? cl_value : '0;
        r.looks_like_response = prefix_ok && (offset >= hrhp_pkg::PrefixLen);
        pending_summaries.push_back(r);
        clear();
      end
    endfunction

    function void compare_field(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        failures++;
      end
    endfunction

    function void check_summary(hrhp_pkg::res_t got);
      hrhp_pkg::res_t want;
      if (pending_summaries.size() == 0) begin
        $error("result transaction with no buffer outstanding");
        failures++;
        return;
      end
      want = pending_summaries.pop_front();
      compare_field("header_found", want.header_found, got.header_found);
      compare_field("header_length", want.header_length, got.header_length);
      compare_field("status_code", want.status_code, got.status_code);
      compare_field("length_found", want.length_found, got.length_found);
      compare_field("content_length", want.content_length, got.content_length);
      compare_field("looks_like_response", want.looks_like_response,
                    got.looks_like_response);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  hrhp_byte_if rx_if ();
  hrhp_res_if  res_if ();

  http_response_header_parser uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  resp_header_scoreboard chk;
  logic [7:0] frame[$];
  int   src_idle_pct;
  int   snk_idle_pct;
  bit   hold_off_go;
  bit   hold_off_done;
  int   hold_off_count;
  int   cycles;
  hrhp_pkg::res_t seen;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // sink side: random back-pressure plus one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (hold_off_go && !hold_off_done) begin
      res_if.ready <= 1'b0;
      hold_off_count++;
      if (hold_off_count >= HoldOffCycles) hold_off_done = 1'b1;
    end else begin
      res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      seen.header_found        = res_if.header_found;
      seen.header_length       = res_if.header_length;
      seen.status_code         = res_if.status_code;
      seen.length_found        = res_if.length_found;
      seen.content_length      = res_if.content_length;
      seen.looks_like_response = res_if.looks_like_response;
      chk.check_summary(seen);
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit is_last);
    bit taken;
    if ($urandom_range(99) < src_idle_pct) begin
      rx_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    rx_if.valid     <= 1'b1;
    rx_if.data_byte <= b;
    rx_if.last_byte <= is_last;
    do begin
      @(negedge clk_i);
      taken = rx_if.ready;
      @(posedge clk_i);
    end while (!taken);
    chk.note_byte(b, is_last);
  endtask

  task automatic send_frame();
    foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
  endtask

  function automatic void add_text(string s);
    foreach (s[i]) frame.push_back(s[i]);
  endfunction

  function automatic void add_mixed_case(string s);
    logic [7:0] c;
    foreach (s[i]) begin
      c = s[i];
      if (c >= "a" && c <= "z" && $urandom_range(1)) c = c - 8'd32;
      frame.push_back(c);
    end
  endfunction

  function automatic void add_digits(int n);
    repeat (n) frame.push_back(hrhp_pkg::ChZero + 8'($urandom_range(9)));
  endfunction

  function automatic void add_break();
    case ($urandom_range(3))
      0, 1: begin
        frame.push_back(hrhp_pkg::ChCr);
        frame.push_back(hrhp_pkg::ChLf);
      end
      2: frame.push_back(hrhp_pkg::ChLf);
      default: frame.push_back(hrhp_pkg::ChCr);
    endcase
  endfunction

  function automatic void add_length_line();
    add_mixed_case("content-length");
    frame.push_back(hrhp_pkg::ChColon);
    repeat ($urandom_range(3)) begin
      frame.push_back($urandom_range(1) ? hrhp_pkg::ChSp : hrhp_pkg::ChTab);
    end
    case ($urandom_range(9))
      0: add_text("4294967295");
      1: add_text("4294967296");
      2: add_digits($urandom_range(11, 14));
      3: ;
      4: add_text("n/a");
      default: add_digits($urandom_range(1, 5));
    endcase
    if ($urandom_range(3) == 0) add_text(" x");
    add_break();
  endfunction

  function automatic void add_other_line();
    case ($urandom_range(6))
      0: add_text("Server: hx");
      1: add_mixed_case("content-type: text");
      2: add_mixed_case("content-lengthx: 7");
      3: add_mixed_case("content-lengt: 8");
      4: add_text("Content_Length: 9");
      5: add_text("X-Content-Length: 5");
      default: add_text("junk line");
    endcase
    add_break();
  endfunction

  function automatic void build_response();
    string head;
    int    n_lines;
    int    cl_line;
    int    keep;
    frame.delete();
    head = "HTTP/1.1";
    case ($urandom_range(9))
      0: head[$urandom_range(4)] = byte'($urandom_range(33, 126));
      1: head = "http/1.0";
      2: head = "HTT";
      default: ;
    endcase
    add_text(head);
    repeat ($urandom_range(3)) frame.push_back(hrhp_pkg::ChSp);
    case ($urandom_range(9))
      0: add_text("65535");
      1: add_text("65536");
      2: add_digits($urandom_range(6, 9));
      3: add_text("x1");
      4: ;
      default: add_digits(3);
    endcase
    if ($urandom_range(1)) add_text(" OK");
    add_break();
    n_lines = $urandom_range(2);
    cl_line = $urandom_range(n_lines);
    for (int i = 0; i <= n_lines; i++) begin
      if (i == cl_line) add_length_line();
      else if (i < n_lines) add_other_line();
    end
    if ($urandom_range(4) == 0) add_length_line();
    add_break();
    repeat ($urandom_range(5)) frame.push_back(8'($urandom_range(255)));
    if ($urandom_range(6) == 0) begin
      keep = $urandom_range(1, frame.size());
      frame = frame[0:keep-1];
    end
  endfunction

  function automatic void build_noise();
    frame.delete();
    repeat ($urandom_range(1, 12)) begin
      case ($urandom_range(3))
        0, 1: frame.push_back(8'($urandom_range(255)));
        2: begin
          case ($urandom_range(3))
            0: frame.push_back(hrhp_pkg::ChCr);
            1: frame.push_back(hrhp_pkg::ChLf);
            2: frame.push_back(hrhp_pkg::ChSp);
            default: frame.push_back(hrhp_pkg::ChColon);
          endcase
        end
        default: frame.push_back(hrhp_pkg::ChZero + 8'($urandom_range(9)));
      endcase
    end
  endfunction

  task automatic run_phase(input int src_pct, input int snk_pct, input bit with_hold);
    int n_bufs;
    int n_bytes;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    n_bufs  = 0;
    n_bytes = 0;
    while (n_bytes < 240 || n_bufs < 4) begin
      if (with_hold && n_bufs == 3) hold_off_go = 1'b1;
      if ($urandom_range(99) < 75) build_response();
      else build_noise();
      n_bytes += frame.size();
      send_frame();
      n_bufs++;
    end
  endtask

  task automatic run_directed();
    frame = {8'hFF};
    send_frame();
    frame = {hrhp_pkg::ChLf, hrhp_pkg::ChLf};
    send_frame();
    // CR as the final byte closes the header
    frame = {hrhp_pkg::ChCr, hrhp_pkg::ChCr};
    send_frame();
    frame = {hrhp_pkg::ChCr, hrhp_pkg::ChCr, 8'h5A};
    send_frame();
    frame = {hrhp_pkg::ChCr, hrhp_pkg::ChLf, hrhp_pkg::ChCr, hrhp_pkg::ChLf};
    send_frame();
    frame.delete();
    add_text("HTTP/");
    send_frame();
    frame = {8'h00};
    add_text(" 9");
    frame.push_back(hrhp_pkg::ChLf);
    frame.push_back(hrhp_pkg::ChLf);
    send_frame();
  endtask

  initial begin
    rst_ni          = 1'b0;
    rx_if.valid     = 1'b0;
    rx_if.data_byte = '0;
    rx_if.last_byte = 1'b0;
    res_if.ready    = 1'b0;
    src_idle_pct    = 29;
    snk_idle_pct    = 65;
    hold_off_go     = 1'b0;
    hold_off_done   = 1'b0;
    hold_off_count  = 0;
    cycles          = 0;
    chk = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_phase(29, 65, 1'b0);
    run_phase(65, 29, 1'b0);
    run_phase(0, 0, 1'b1);
    rx_if.valid <= 1'b0;

    while (chk.pending_summaries.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (chk.failures == 0 && chk.pending_summaries.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/hrhp_pkg.sv
rtl/hrhp_if.sv
rtl/hrhp_front.sv
rtl/hrhp_fifo.sv
rtl/hrhp_back.sv
rtl/http_response_header_parser.sv
rtl/hrhp_checker.sv
verif/tb_top.sv
